/* src/sird_pkg.sv */
// sird_pkg: shared types and constants for the signed integer to radix digits block.
// Holds sequencer states, register indexes, character codes and reset values.
// No dependencies.
package sird_pkg;

  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 32;

  localparam int SYM_W    = 8;
  localparam int DIGIT_W  = $clog2(MAX_RADIX);
  localparam int RADIX_W  = 5;
  localparam int COUNT_W  = $clog2(MAX_DIGITS) + 1;
  localparam int ADDR_W   = $clog2(MAX_DIGITS);
  localparam int DATA_W   = 32;
  localparam int STEP_W   = $clog2(DATA_W);
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic [SYM_W-1:0]   symbol_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Character codes
  localparam symbol_t SYM_PLUS  = 8'h2B;
  localparam symbol_t SYM_MINUS = 8'h2D;
  localparam symbol_t SYM_NONE  = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Reset values: base ten, symbols "0123456789ABCDEF"
  localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
  localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RESET = 64'h4645_4443_4241_3938;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_BAD    = 5'b10000
  } state_t;

endpackage

/* src/signed_int_to_radix_digits.sv */
// signed_int_to_radix_digits: converts a signed 32-bit value to digit symbols in a
// configured radix, minus sign first, most significant digit first.
// Depends on sird_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_stall | number
//   out     | output    | out_valid/out_stall | symbol, is_last, base_invalid
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// An accepted number first has the used symbols of its base checked one at a time,
// then each digit comes from the shared restoring divider (one quotient bit a
// cycle), then the minus sign and the digits are emitted one symbol at a time.
// An invalid base skips the divider and emits one transaction.
// Reset is synchronous; no clearing pass. Output stalls hold the sequencer only while it emits.
module signed_int_to_radix_digits (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          symbol,
  output logic                is_last,
  output logic                base_invalid,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  // Configuration registers
  logic [sird_pkg::RADIX_W-1:0] radix;
  logic [sird_pkg::CFG_W-1:0]   symbols_low;
  logic [sird_pkg::CFG_W-1:0]   symbols_high;

  // Sequencer and datapath registers
  sird_pkg::state_t state;
  logic [sird_pkg::DIGIT_W-1:0] chk_idx;
  logic [sird_pkg::DATA_W-1:0]  quotient;
  logic [sird_pkg::DIGIT_W-1:0] rem;
  logic [sird_pkg::STEP_W-1:0]  step;
  logic [sird_pkg::COUNT_W-1:0] digit_count;
  logic [sird_pkg::COUNT_W-1:0] emit_idx;
  logic                         negative_flag;
  logic                         minus_pending;
  sird_pkg::digit_t             digit_store [sird_pkg::MAX_DIGITS];

  // Combinational signals
  sird_pkg::symbol_t            sym [sird_pkg::MAX_RADIX];
  sird_pkg::symbol_t            cur_sym;
  logic                         dup_hit;
  logic                         sym_bad;
  logic [sird_pkg::DIGIT_W-1:0] last_chk;
  logic                         radix_ok;
  logic                         in_accept;
  logic                         out_free;
  logic [sird_pkg::RADIX_W-1:0] trial;
  logic                         trial_ge;
  logic [sird_pkg::RADIX_W-1:0] rem_next;
  logic [sird_pkg::DATA_W-1:0]  quotient_next;
  logic [sird_pkg::DATA_W-1:0]  magnitude;
  logic [sird_pkg::ADDR_W-1:0]  rd_addr;
  sird_pkg::digit_t             rd_digit;

  assign in_stall  = (state != sird_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Unpack symbol table
  always_comb begin
    for (int i = 0; i < sird_pkg::MAX_RADIX; i++) begin
      if (i < 8) begin
        sym[i] = symbols_low[i*8 +: 8];
      end else begin
        sym[i] = symbols_high[(i-8)*8 +: 8];
      end
    end
  end

  // Base check: one used symbol per cycle against all later used symbols
  assign cur_sym  = sym[chk_idx];
  assign last_chk = sird_pkg::DIGIT_W'(radix - 5'd1);
  assign radix_ok = (radix >= 5'd2) && (radix <= 5'(sird_pkg::MAX_RADIX));

  always_comb begin
    dup_hit = 1'b0;
    for (int j = 0; j < sird_pkg::MAX_RADIX; j++) begin
      if ((sird_pkg::DIGIT_W'(j) > chk_idx) && (5'(j) < radix) && (sym[j] == cur_sym)) begin
        dup_hit = 1'b1;
      end
    end
  end

  assign sym_bad = dup_hit || (cur_sym == sird_pkg::SYM_NONE) ||
                   (cur_sym == sird_pkg::SYM_PLUS) || (cur_sym == sird_pkg::SYM_MINUS);

  // Restoring divider step: one quotient bit per cycle
  assign trial         = {rem, quotient[sird_pkg::DATA_W-1]};
  assign trial_ge      = (trial >= radix);
  assign rem_next      = trial_ge ? (trial - radix) : trial;
  assign quotient_next = {quotient[sird_pkg::DATA_W-2:0], trial_ge};

  // Magnitude of the input; the most negative value wraps to itself unsigned
  assign magnitude = 32'd0 - $unsigned(number);

  // Digit read for emission
  assign rd_addr  = sird_pkg::ADDR_W'(emit_idx - 6'd1);
  assign rd_digit = digit_store[rd_addr];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= sird_pkg::RADIX_RESET;
      symbols_low  <= sird_pkg::SYMBOLS_LOW_RESET;
      symbols_high <= sird_pkg::SYMBOLS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sird_pkg::REG_RADIX:        radix        <= cfg_data[sird_pkg::RADIX_W-1:0];
        sird_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        sird_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Digit store: write one digit at the end of each division
  always_ff @(posedge clk) begin
    if ((state == sird_pkg::ST_DIVIDE) && (step == sird_pkg::STEP_W'(sird_pkg::DATA_W - 1))) begin
      digit_store[sird_pkg::ADDR_W'(digit_count)] <= rem_next[sird_pkg::DIGIT_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sird_pkg::ST_IDLE;
      chk_idx       <= '0;
      step          <= '0;
      digit_count   <= '0;
      emit_idx      <= '0;
      negative_flag <= 1'b0;
      minus_pending <= 1'b0;
      quotient      <= '0;
      rem           <= '0;
    end else begin
      unique case (state)
        sird_pkg::ST_IDLE: begin
          // Latch sign and magnitude; start the base check, or go to ST_BAD on a bad radix
          if (in_accept) begin
            negative_flag <= number[31];
            quotient      <= number[31] ? magnitude : $unsigned(number);
            rem           <= '0;
            step          <= '0;
            digit_count   <= '0;
            chk_idx       <= '0;
            state         <= radix_ok ? sird_pkg::ST_CHECK : sird_pkg::ST_BAD;
          end
        end
        sird_pkg::ST_CHECK: begin
          if (sym_bad) begin
            state <= sird_pkg::ST_BAD;
          end else if (chk_idx == last_chk) begin
            state <= sird_pkg::ST_DIVIDE;
          end else begin
            chk_idx <= chk_idx + 4'd1;
          end
        end
        sird_pkg::ST_DIVIDE: begin
          // Advance one bit; at the last bit store the digit and decide
          quotient <= quotient_next;
          if (step == sird_pkg::STEP_W'(sird_pkg::DATA_W - 1)) begin
            digit_count <= digit_count + 6'd1;
            rem         <= '0;
            step        <= '0;
            if ((quotient_next != '0) &&
                ((digit_count + 6'd1) < 6'(sird_pkg::MAX_DIGITS))) begin
              state <= sird_pkg::ST_DIVIDE;
            end else begin
              emit_idx      <= digit_count + 6'd1;
              minus_pending <= negative_flag;
              state         <= sird_pkg::ST_EMIT;
            end
          end else begin
            rem  <= rem_next[sird_pkg::DIGIT_W-1:0];
            step <= step + 5'd1;
          end
        end
        sird_pkg::ST_EMIT: begin
          // Minus sign first, then digits from the most significant down
          if (out_free) begin
            if (minus_pending) begin
              minus_pending <= 1'b0;
            end else begin
              emit_idx <= emit_idx - 6'd1;
              if (emit_idx == 6'd1) begin
                state <= sird_pkg::ST_IDLE;
              end
            end
          end
        end
        sird_pkg::ST_BAD: begin
          if (out_free) begin
            state <= sird_pkg::ST_IDLE;
          end
        end
        default: state <= sird_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && ((state == sird_pkg::ST_EMIT) || (state == sird_pkg::ST_BAD))) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == sird_pkg::ST_BAD) begin
        symbol       <= sird_pkg::SYM_NONE;
        is_last      <= 1'b1;
        base_invalid <= 1'b1;
      end else if (state == sird_pkg::ST_EMIT) begin
        base_invalid <= 1'b0;
        if (minus_pending) begin
          symbol  <= sird_pkg::SYM_MINUS;
          is_last <= 1'b0;
        end else begin
          symbol  <= sym[rd_digit];
          is_last <= (emit_idx == 6'd1);
        end
      end
    end
  end

endmodule

/* src/sird_checker.sv */
// sird_checker: port-level checks for signed_int_to_radix_digits, bound to the top level.
// Sees only the top level's ports. Depends on nothing else.
module sird_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         symbol,
  input logic               is_last,
  input logic               base_invalid
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(is_last) &&
      $stable(base_invalid))
    else $error("stalled output transaction changed");

  // Busy after an accepted input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while still converting");

  // An invalid base gives a single null symbol
  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_invalid |-> (symbol == 8'h00) && is_last)
    else $error("invalid-base result malformed");

  // A valid-base symbol is never null
  a_symbol_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !base_invalid |-> (symbol != 8'h00))
    else $error("null symbol emitted on valid base");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (.*);

/* dv/tb_signed_int_to_radix_digits.sv */
// tb_signed_int_to_radix_digits: self-checking bench for the radix digit converter.
// Predicts the symbol stream of every number from a mirror of the base registers.
// Depends on sird_pkg and signed_int_to_radix_digits.
`timescale 1ns / 100ps

module tb_signed_int_to_radix_digits;

  localparam int IDLE_PCT     = 12;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE_CYC   = 20;
  localparam int PHASE_ITEMS  = 18;
  localparam int RANDOM_PHASES = 9;

  typedef struct packed {
    sird_pkg::symbol_t code;
    logic              last;
    logic              invalid;
  } glyph_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [31:0]  number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          symbol;
  logic                is_last;
  logic                base_invalid;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = sird_pkg::REG_RADIX;
  logic [63:0]         cfg_data = '0;

  // Mirror of the base registers
  logic [sird_pkg::RADIX_W-1:0] radix_cfg = sird_pkg::RADIX_RESET;
  logic [sird_pkg::CFG_W-1:0]   symbols_low_cfg = sird_pkg::SYMBOLS_LOW_RESET;
  logic [sird_pkg::CFG_W-1:0]   symbols_high_cfg = sird_pkg::SYMBOLS_HIGH_RESET;

  logic signed [31:0]  pending_numbers[$];
  glyph_t              expected_glyphs[$];
  logic                no_idle = 1'b0;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  signed_int_to_radix_digits DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number       (number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .is_last      (is_last),
    .base_invalid (base_invalid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic sird_pkg::symbol_t symbol_of(input logic [3:0] idx);
    logic [sird_pkg::CFG_W-1:0] word;
    word = idx[3] ? symbols_high_cfg : symbols_low_cfg;
    return word[8*idx[2:0] +: 8];
  endfunction

  // Work out the symbol stream of one number under the current base
  task automatic predict_symbols(input logic [31:0] value);
    logic [31:0]       magnitude;
    logic [31:0]       base;
    logic [3:0]        digits[sird_pkg::MAX_DIGITS];
    sird_pkg::symbol_t s;
    logic              base_good;
    int                count;
    int                i;
    int                j;
    base_good = (radix_cfg >= 2) && (radix_cfg <= sird_pkg::MAX_RADIX);
    if (base_good) begin
      for (i = 0; i < radix_cfg; i++) begin
        s = symbol_of(i[3:0]);
        if (s == sird_pkg::SYM_NONE || s == sird_pkg::SYM_PLUS || s == sird_pkg::SYM_MINUS)
          base_good = 1'b0;
        for (j = i + 1; j < radix_cfg; j++)
          if (symbol_of(j[3:0]) == s) base_good = 1'b0;
      end
    end
    if (!base_good) begin
      expected_glyphs.push_back('{sird_pkg::SYM_NONE, 1'b1, 1'b1});
      return;
    end
    base = {27'd0, radix_cfg};
    magnitude = value[31] ? -value : value;
    count = 0;
    do begin
      digits[count] = 4'(magnitude % base);
      magnitude = magnitude / base;
      count++;
    end while (magnitude != 0 && count < sird_pkg::MAX_DIGITS);
    if (value[31]) expected_glyphs.push_back('{sird_pkg::SYM_MINUS, 1'b0, 1'b0});
    for (i = count - 1; i >= 0; i--)
      expected_glyphs.push_back('{symbol_of(digits[i]), i == 0, 1'b0});
  endtask

  // Driver: present pending numbers, predict at each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_symbols(number);
      if (pending_numbers.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        number   <= pending_numbers.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random, check each accepted symbol transaction
  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_glyphs.size() == 0) begin
          $error("unexpected symbol transaction: symbol %02h is_last %b base_invalid %b",
                 symbol, is_last, base_invalid);
          mismatch_count++;
        end else begin
          want = expected_glyphs.pop_front();
          if (symbol !== want.code) begin
            $error("symbol: expected %02h, actual %02h", want.code, symbol);
            mismatch_count++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %b, actual %b", want.last, is_last);
            mismatch_count++;
          end
          if (base_invalid !== want.invalid) begin
            $error("base_invalid: expected %b, actual %b", want.invalid, base_invalid);
            mismatch_count++;
          end
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write all three base registers; only called while the block is idle
  task automatic apply_base(input logic [sird_pkg::RADIX_W-1:0] r,
                            input logic [sird_pkg::CFG_W-1:0] lo,
                            input logic [sird_pkg::CFG_W-1:0] hi);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sird_pkg::REG_RADIX;
    cfg_data  <= {59'd0, r};
    @(posedge clk);
    cfg_index <= sird_pkg::REG_SYMBOLS_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= sird_pkg::REG_SYMBOLS_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_cfg        = r;
    symbols_low_cfg  = lo;
    symbols_high_cfg = hi;
  endtask

  // Hold until every number is accepted and every symbol has arrived
  task automatic drain_block();
    while (pending_numbers.size() > 0 || in_valid || expected_glyphs.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic directed_base(input logic [sird_pkg::RADIX_W-1:0] r,
                               input logic [sird_pkg::CFG_W-1:0] lo,
                               input logic [sird_pkg::CFG_W-1:0] hi,
                               input logic [31:0] value);
    apply_base(r, lo, hi);
    pending_numbers.push_back(value);
    drain_block();
  endtask

  // Mostly valid bases with distinct legal symbols; now and then anything goes
  task automatic random_base();
    logic [sird_pkg::RADIX_W-1:0] r;
    logic [7:0]                   syms[sird_pkg::MAX_RADIX];
    logic [sird_pkg::CFG_W-1:0]   lo;
    logic [sird_pkg::CFG_W-1:0]   hi;
    logic                         clash;
    int                           i;
    int                           j;
    if ($urandom_range(0, 9) == 0) begin
      r = 5'($urandom_range(0, 31));
      for (i = 0; i < sird_pkg::MAX_RADIX; i++) syms[i] = 8'($urandom_range(0, 255));
    end else begin
      r = 5'($urandom_range(2, sird_pkg::MAX_RADIX));
      for (i = 0; i < sird_pkg::MAX_RADIX; i++) begin
        if (i < r) begin
          do begin
            syms[i] = 8'($urandom_range(1, 255));
            clash = (syms[i] == sird_pkg::SYM_PLUS) || (syms[i] == sird_pkg::SYM_MINUS);
            for (j = 0; j < i; j++) if (syms[j] == syms[i]) clash = 1'b1;
          end while (clash);
        end else begin
          syms[i] = 8'($urandom_range(0, 255));
        end
      end
    end
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = syms[i];
      hi[8*i +: 8] = syms[i+8];
    end
    apply_base(r, lo, hi);
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom;
      4, 5, 6:    value = $urandom_range(0, 600) - 300;
      7: begin
        case ($urandom_range(0, 3))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = 32'h0000_0000;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        value = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) value = -value;
      end
    endcase
    return value;
  endfunction

  initial begin
    logic [sird_pkg::CFG_W-1:0] lo;
    logic [sird_pkg::CFG_W-1:0] hi;
    int                         p;
    int                         k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset base: decimal, zero, extremes, signs
    pending_numbers.push_back(32'sd0);
    pending_numbers.push_back(32'sd7);
    pending_numbers.push_back(-32'sd1);
    pending_numbers.push_back(32'sh7FFF_FFFF);
    pending_numbers.push_back(32'sh8000_0000);
    pending_numbers.push_back(-32'sd1000);
    drain_block();

    // Binary: longest outputs
    apply_base(5'd2, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET);
    pending_numbers.push_back(32'sh8000_0000);
    pending_numbers.push_back(32'sh7FFF_FFFF);
    pending_numbers.push_back(32'shAAAA_AAAA);
    drain_block();

    // Hexadecimal: every symbol in use
    apply_base(5'd16, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET);
    pending_numbers.push_back(32'sh0123_4567);
    pending_numbers.push_back(32'sh89AB_CDEF);
    pending_numbers.push_back(32'sd0);
    drain_block();

    // Bases too short or too long
    directed_base(5'd0, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET, 32'sd42);
    directed_base(5'd1, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET, -32'sd42);
    directed_base(5'd17, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET, 32'sd5);
    directed_base(5'd31, sird_pkg::SYMBOLS_LOW_RESET, sird_pkg::SYMBOLS_HIGH_RESET, 32'sd5);

    // Forbidden symbols among the used ones
    lo = sird_pkg::SYMBOLS_LOW_RESET;
    lo[31:24] = sird_pkg::SYM_PLUS;
    directed_base(5'd10, lo, sird_pkg::SYMBOLS_HIGH_RESET, 32'sd99);
    hi = sird_pkg::SYMBOLS_HIGH_RESET;
    hi[15:8] = sird_pkg::SYM_MINUS;
    directed_base(5'd10, sird_pkg::SYMBOLS_LOW_RESET, hi, 32'sd99);
    lo = sird_pkg::SYMBOLS_LOW_RESET;
    lo[7:0] = sird_pkg::SYM_NONE;
    directed_base(5'd2, lo, sird_pkg::SYMBOLS_HIGH_RESET, 32'sd3);
    hi = sird_pkg::SYMBOLS_HIGH_RESET;
    hi[63:56] = sird_pkg::SYM_MINUS;
    directed_base(5'd16, sird_pkg::SYMBOLS_LOW_RESET, hi, 32'sd3);

    // Repeated symbol across the two words
    hi = sird_pkg::SYMBOLS_HIGH_RESET;
    hi[7:0] = sird_pkg::SYMBOLS_LOW_RESET[15:8];
    directed_base(5'd16, sird_pkg::SYMBOLS_LOW_RESET, hi, 32'sd77);

    // Bytes beyond the radix are ignored, even zeros, signs and repeats
    lo = sird_pkg::SYMBOLS_LOW_RESET;
    lo[63:32] = {sird_pkg::SYM_NONE, sird_pkg::SYM_PLUS, sird_pkg::SYM_MINUS, lo[7:0]};
    directed_base(5'd4, lo, 64'h0, -32'sd12345);
    pending_numbers.push_back(32'sh7FFF_FFFF);
    drain_block();

    // Random bases and numbers, one phase with no idling on either side
    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_base();
      no_idle = (p == RANDOM_PHASES / 2);
      for (k = 0; k < PHASE_ITEMS; k++) pending_numbers.push_back(random_number());
      drain_block();
    end
    no_idle = 1'b0;

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/sird_pkg.sv
src/signed_int_to_radix_digits.sv
src/sird_checker.sv
dv/tb_signed_int_to_radix_digits.sv
